[hdl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and character codes shared by the JSON string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_OPEN = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FIN_MORE = 2'd0,
    FIN_DONE = 2'd1,
    FIN_ERR  = 2'd2
  } finish_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChTab       = 8'h09;

  localparam int unsigned HexValueW = 7;
  localparam int unsigned DataW     = 8;
  localparam int unsigned UserW     = 8;

  typedef struct packed {
    mode_e                 mode;
    logic [1:0]            hex_count;
    logic [HexValueW-1:0]  hex_value;
    logic                  hex_still_digits;
  } parse_state_t;

  typedef struct packed {
    logic              present;
    logic [DataW-1:0]  data_byte;
    logic              data_valid;
    finish_e           finish;
  } result_t;

  localparam parse_state_t StateReset = '{
    mode:             MODE_OPEN,
    hex_count:        2'd0,
    hex_value:        '0,
    hex_still_digits: 1'b1
  };

endpackage

[hdl/jsu_step.sv]
// ----------------------------------------------------------------------------
// jsu_step
// Decodes one byte against the parser state: next state and optional result.
// ----------------------------------------------------------------------------
module jsu_step import jsu_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output parse_state_t state_o,
  output result_t      result_o
);

  logic       is_hex;
  logic [3:0] hex_nibble;

  always_comb begin
    is_hex     = 1'b1;
    hex_nibble = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_nibble = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_nibble = byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{present: 1'b0, data_byte: '0, data_valid: 1'b0, finish: FIN_MORE};
    case (state_i.mode)
      MODE_OPEN: begin
        if (byte_i != ChQuote || last_i) begin
          result_o.present = 1'b1;
          result_o.finish  = FIN_ERR;
        end else begin
          state_o.mode = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (byte_i == ChQuote) begin
          result_o.present = 1'b1;
          result_o.finish  = FIN_DONE;
        end else if (last_i) begin
          result_o.present = 1'b1;
          result_o.finish  = FIN_ERR;
        end else if (byte_i == ChBackslash) begin
          state_o.mode = MODE_ESC;
        end else begin
          result_o.present    = 1'b1;
          result_o.data_byte  = byte_i;
          result_o.data_valid = 1'b1;
        end
      end
      MODE_ESC: begin
        if (last_i) begin
          result_o.present = 1'b1;
          result_o.finish  = FIN_ERR;
        end else if (byte_i == ChLowerU) begin
          state_o = StateReset;
          state_o.mode = MODE_HEX;
        end else begin
          state_o.mode        = MODE_BODY;
          result_o.present    = 1'b1;
          result_o.data_valid = 1'b1;
          case (byte_i)
            ChLowerN: result_o.data_byte = ChLf;
            ChLowerR: result_o.data_byte = ChCr;
            ChLowerT: result_o.data_byte = ChTab;
            default:  result_o.data_byte = byte_i;
          endcase
        end
      end
      MODE_HEX: begin
        if (last_i) begin
          result_o.present = 1'b1;
          result_o.finish  = FIN_ERR;
        end else begin
          if (state_i.hex_still_digits && is_hex) begin
            state_o.hex_value = {state_i.hex_value[HexValueW-5:0], hex_nibble};
          end else begin
            state_o.hex_still_digits = 1'b0;
          end
          if (state_i.hex_count == 2'd3) begin
            result_o.present    = 1'b1;
            result_o.data_byte  = {1'b0, state_o.hex_value};
            result_o.data_valid = 1'b1;
            state_o             = StateReset;
            state_o.mode        = MODE_BODY;
          end else begin
            state_o.hex_count = state_i.hex_count + 2'd1;
          end
        end
      end
      default: begin
        state_o = StateReset;
      end
    endcase
    if (result_o.finish != FIN_MORE) begin
      state_o = StateReset;
    end
  end

endmodule

[hdl/json_string_unescaper.sv]
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes the bytes of a JSON quoted string into its characters.
// ----------------------------------------------------------------------------
// The input stream carries the JSON text, one byte per item, with tlast
// marking the last byte of the available text. The first byte of a string
// must be a double quote. The output stream carries at most one item per
// input byte: a decoded character with data_valid set, or a finish code
// (closing quote seen, or error) that ends the string. Opening quotes,
// backslashes and the leading bytes of a hex escape give no output item.
// The output item of an accepted byte is registered, and the block takes one
// byte in every cycle unless the output is stalled; the decode is one short
// step between the parser state and the output register. After reset the
// parser waits for an opening quote and the output register is empty. When
// the receiver stalls, the output item holds and the input side accepts a
// new byte only in the cycle in which the held item leaves.
// ----------------------------------------------------------------------------
module json_string_unescaper import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic             s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [7:0] data_byte
  output logic [UserW-1:0] m_axis_tuser    // [0] data_valid, [2:1] finish, [7:3] zero
);

  parse_state_t     state_q, state_d, step_state;
  result_t          step_result;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q;
  logic             out_dvalid_q;
  finish_e          out_finish_q;
  logic             accept;

  jsu_step u_step (
    .state_i  (state_q),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .state_o  (step_state),
    .result_o (step_result)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = accept ? step_state : state_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = step_result.present;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step_result.present) begin
      out_data_q   <= step_result.data_byte;
      out_dvalid_q <= step_result.data_valid;
      out_finish_q <= step_result.finish;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {{(UserW-3){1'b0}}, out_finish_q, out_dvalid_q};

endmodule

[hdl/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic [UserW-1:0] m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output is stalled");

  a_finish_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] != FIN_MORE |->
      !m_axis_tuser[0] && m_axis_tdata == '0 && m_axis_tuser[2:1] != 2'd3)
    else $error("finish item carries data or a bad code");

  a_tuser_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[UserW-1:3] == '0 &&
      (m_axis_tuser[0] || m_axis_tuser[2:1] != FIN_MORE))
    else $error("output item is neither a character nor a finish");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
